// ===== hdl/ldpc_enc_pkg.sv =====
`timescale 1ns / 1ps

package ldpc_enc_pkg;

	// Request codes carried in req_type.
	localparam logic [1:0] REQ_MATRIX = 2'd0;
	localparam logic [1:0] REQ_INFO   = 2'd1;
	localparam logic [1:0] REQ_PARITY = 2'd2;

	// Value of info_length after reset.
	localparam logic [7:0] INFO_LENGTH_RESET = 8'd100;

	// Low six bits of the field polynomial x^6+x+1; x^6 reduces to x+1.
	localparam logic [5:0] GF_POLY_LOW = 6'h03;

	typedef struct packed {
		logic [1:0] req_type;
		logic [6:0] row_index;
		logic [6:0] col_index;
		logic [5:0] symbol_value;
	} enc_req_t;

	typedef struct packed {
		logic [6:0] parity_index;
		logic [5:0] parity_symbol;
	} enc_rsp_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} enc_state_t;

endpackage

// ===== hdl/ldpc_enc_ram.sv =====
`timescale 1ns / 1ps

module ldpc_enc_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 128
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/ldpc_gf64_parity_encoder.sv =====
`timescale 1ns / 1ps

// Parity generator for a systematic non-binary LDPC code over GF(64).
//
// Items arrive on the req channel (req_valid, req_stall, req). A matrix write
// or an info symbol write gives no result and leaves the block idle, so such
// items may follow one another in every cycle. A parity item walks one row of
// the generator memory together with the message memory, one entry per cycle,
// and XORs the GF(64) products into an accumulator. With L the effective
// length (info_length, saturated at MAX_SYMBOLS) the walk reads L entries;
// req_stall stays high until the result is loaded into the output register,
// so no new item is taken while a parity item is in progress.
// Results leave through the rsp channel (rsp_valid, rsp_stall, rsp) from an
// output register. If the receiver stalls while a new result is ready, the
// block holds that result in its accumulator and keeps req_stall high until
// the output register frees up; nothing is dropped.
// info_length is written through cfg_valid/cfg_ready/cfg_data; cfg_ready is
// always high and writes are only expected while the block is idle.
// Reset (arst_n low) empties the output register, returns to idle and sets
// info_length to 100. Both memories are undefined until written: no entry
// may be used by a parity item before software has loaded it.

module ldpc_gf64_parity_encoder
	import ldpc_enc_pkg::*;
#(
	parameter int MAX_SYMBOLS = 128
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  enc_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output enc_rsp_t rsp,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  logic [7:0] cfg_data
);

	localparam int GEN_DEPTH = MAX_SYMBOLS * MAX_SYMBOLS;
	localparam int GEN_AW    = GEN_DEPTH > 1 ? $clog2(GEN_DEPTH) : 1;
	localparam int MSG_AW    = MAX_SYMBOLS > 1 ? $clog2(MAX_SYMBOLS) : 1;
	// The column counter must be able to hold the length itself.
	localparam int LW        = $clog2(MAX_SYMBOLS + 1);

	// Carry-less product reduced by the field polynomial, one bit of b a step.
	function automatic logic [5:0] gf64_mul(input logic [5:0] a, input logic [5:0] b);
		logic [5:0] p;
		logic [5:0] x;
		p = '0;
		x = a;
		for (int i = 0; i < 6; i++) begin
			if (b[i]) begin
				p = p ^ x;
			end
			x = {x[4:0], 1'b0} ^ (x[5] ? GF_POLY_LOW : 6'h00);
		end
		return p;
	endfunction

	enc_state_t state_q, state_d;

	logic [7:0]    info_length_q;
	logic [6:0]    row_q;
	logic [LW-1:0] len_q;
	logic [LW-1:0] cnt_q;
	logic          rd_vld_s1;
	logic [5:0]    acc_q;
	logic          rsp_valid_q;
	enc_rsp_t      rsp_q;

	logic          req_accept;
	logic          rsp_free;
	logic          issue;
	logic          done;
	logic          load_rsp;
	logic          start;
	logic [LW-1:0] len_eff;

	logic              gen_we;
	logic [GEN_AW-1:0] gen_waddr;
	logic [GEN_AW-1:0] gen_raddr;
	logic [5:0]        gen_rdata;
	logic              msg_we;
	logic [MSG_AW-1:0] msg_waddr;
	logic [5:0]        msg_rdata;

	logic row_in_range;
	logic col_in_range;

	assign req_accept = req_valid && !req_stall;
	assign rsp_free   = !rsp_valid_q || !rsp_stall;
	assign cfg_ready  = 1'b1;
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;

	assign row_in_range = 32'(req.row_index) < MAX_SYMBOLS;
	assign col_in_range = 32'(req.col_index) < MAX_SYMBOLS;

	// Length seen by a parity item: info_length saturated at the store size.
	assign len_eff = (32'(info_length_q) > MAX_SYMBOLS) ? LW'(MAX_SYMBOLS)
	                                                     : LW'(info_length_q);

	// Memory writes are taken straight from an accepted item.
	assign gen_we    = req_accept && (req.req_type == REQ_MATRIX) && row_in_range
	                   && col_in_range;
	assign gen_waddr = GEN_AW'(32'(req.row_index) * MAX_SYMBOLS + 32'(req.col_index));
	assign msg_we    = req_accept && (req.req_type == REQ_INFO) && col_in_range;
	assign msg_waddr = MSG_AW'(req.col_index);

	assign gen_raddr = GEN_AW'(32'(row_q) * MAX_SYMBOLS + 32'(cnt_q));

	// Next state and sequencing strobes. In idle the input is never stalled,
	// so a valid item is an accepted one.
	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		start     = 1'b0;
		issue     = 1'b0;
		done      = 1'b0;
		load_rsp  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid && (req.req_type == REQ_PARITY)) begin
					start   = 1'b1;
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				issue = (cnt_q != len_q);
				done  = (cnt_q == len_q) && !rd_vld_s1;
				if (done && rsp_free) begin
					load_rsp = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers: column counter, read valid, output valid, length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q         <= '0;
			rd_vld_s1     <= 1'b0;
			rsp_valid_q   <= 1'b0;
			info_length_q <= INFO_LENGTH_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				info_length_q <= cfg_data;
			end
			if (start) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			rd_vld_s1 <= issue;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers. A row beyond the store gives an empty sum.
	always_ff @(posedge clk) begin
		if (start) begin
			row_q <= req.row_index;
			len_q <= row_in_range ? len_eff : '0;
			acc_q <= '0;
		end else if (rd_vld_s1) begin
			acc_q <= acc_q ^ gf64_mul(gen_rdata, msg_rdata);
		end
		if (load_rsp) begin
			rsp_q.parity_index  <= row_q;
			rsp_q.parity_symbol <= acc_q;
		end
	end

	ldpc_enc_ram #(
		.WIDTH(6),
		.DEPTH(GEN_DEPTH)
	) u_gen_ram (
		.clk  (clk),
		.we   (gen_we),
		.waddr(gen_waddr),
		.wdata(req.symbol_value),
		.re   (issue),
		.raddr(gen_raddr),
		.rdata(gen_rdata)
	);

	ldpc_enc_ram #(
		.WIDTH(6),
		.DEPTH(MAX_SYMBOLS)
	) u_msg_ram (
		.clk  (clk),
		.we   (msg_we),
		.waddr(msg_waddr),
		.wdata(req.symbol_value),
		.re   (issue),
		.raddr(cnt_q[MSG_AW-1:0]),
		.rdata(msg_rdata)
	);

endmodule

// ===== tb/tb_ldpc_gf64_parity_encoder.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the GF(64) parity generator.
module tb_ldpc_gf64_parity_encoder;
	import ldpc_enc_pkg::*;

	localparam int SYM_CNT      = 128;
	// This hold-off outlasts the longest parity walk, so it covers any item in flight.
	localparam int HOLD_CYCLES  = SYM_CNT + 12;
	localparam int LIMIT_CYCLES = 5_000_000;
	localparam int PHASE_ITEMS  = 45;
	localparam int DIR_CNT      = 22;

	// Request code 3 has no meaning and the block is to ignore it.
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	// One row of the directed table. A fill row expands into a write of every
	// column (matrix row) or every position (message) with the same value.
	typedef struct packed {
		logic       fill;
		logic       typed;
		logic [5:0] sym;
		enc_req_t   item;
	} dir_row_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	enc_req_t   req       = '0;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;
	enc_rsp_t   rsp;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data  = '0;

	ldpc_gf64_parity_encoder #(
		.MAX_SYMBOLS(SYM_CNT)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// The bench's own copy of the block's memories and length register. The
	// loaded flags record which entries have been written, so that a parity
	// item is only sent once every entry that it reads holds a defined value.
	logic [5:0] gen_mem    [SYM_CNT][SYM_CNT];
	logic [5:0] msg_mem    [SYM_CNT];
	bit         gen_loaded [SYM_CNT][SYM_CNT];
	bit         msg_loaded [SYM_CNT];
	logic [7:0] len_reg = INFO_LENGTH_RESET;

	// Parity results still owed by the block, oldest first.
	enc_rsp_t parity_due [$];

	dir_row_t dir_tab [DIR_CNT];

	int  err_cnt   = 0;
	int  n_items   = 0;
	int  n_results = 0;
	int  n_cfg     = 0;
	int  n_cycles  = 0;
	int  pend_gap  = 0;
	int  rsp_wait  = 0;
	bit  no_idle   = 1'b0;

	// Carry-less product reduced by x^6+x+1: each shift that carries out of
	// bit 5 folds x^6 back in as x+1.
	function automatic logic [5:0] gf64_product(input logic [5:0] a, input logic [5:0] b);
		logic [5:0] acc;
		logic [5:0] sh;
		acc = '0;
		sh  = a;
		for (int i = 0; i < 6; i++) begin
			if (b[i]) begin
				acc ^= sh;
			end
			sh = sh[5] ? ({sh[4:0], 1'b0} ^ GF_POLY_LOW) : {sh[4:0], 1'b0};
		end
		return acc;
	endfunction

	// Lengths above the memory size saturate.
	function automatic int eff_len();
		return (int'(len_reg) > SYM_CNT) ? SYM_CNT : int'(len_reg);
	endfunction

	function automatic logic [5:0] predict_parity(input logic [6:0] row);
		logic [5:0] acc;
		acc = '0;
		for (int j = 0; j < eff_len(); j++) begin
			acc ^= gf64_product(gen_mem[row][j], msg_mem[j]);
		end
		return acc;
	endfunction

	function automatic enc_req_t make_req(input logic [1:0] rt, input logic [6:0] r,
		input logic [6:0] c, input logic [5:0] v);
		enc_req_t it;
		it.req_type     = rt;
		it.row_index    = r;
		it.col_index    = c;
		it.symbol_value = v;
		return it;
	endfunction

	function automatic dir_row_t step_row(input logic fill, input logic typed,
		input logic [5:0] sym, input logic [1:0] rt, input logic [6:0] r,
		input logic [6:0] c, input logic [5:0] v);
		dir_row_t d;
		d.fill  = fill;
		d.typed = typed;
		d.sym   = sym;
		d.item  = make_req(rt, r, c, v);
		return d;
	endfunction

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 7);
	endfunction

	// Most traffic goes to a handful of rows so that they are reused; the rest
	// is spread over every row so that each index bit toggles.
	function automatic logic [6:0] pick_row();
		return ($urandom_range(0, 3) != 0) ? 7'($urandom_range(0, 7)) : 7'($urandom_range(0, 127));
	endfunction

	// Parity items go to a few rows, so that loading what they read stays
	// cheap; the top row makes every bit of the index toggle.
	function automatic logic [6:0] pick_parity_row();
		int k;
		k = $urandom_range(0, 3);
		return (k == 3) ? 7'd127 : 7'(k);
	endfunction

	function automatic logic [6:0] pick_col(input int n);
		if (n > 0 && $urandom_range(0, 9) < 7) begin
			return 7'($urandom_range(0, n - 1));
		end
		return 7'($urandom_range(0, 127));
	endfunction

	// Zero and the all-ones element come up more often than a flat draw gives.
	function automatic logic [5:0] rand_sym();
		int k;
		k = $urandom_range(0, 9);
		if (k == 0) begin
			return 6'd0;
		end
		if (k == 1) begin
			return 6'h3F;
		end
		return 6'($urandom_range(0, 63));
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		err_cnt++;
	endtask

	// Called at the edge where an item is accepted: writes update the local
	// memories, a parity item queues its expected result. A typed value from
	// the directed table takes the place of the predicted one.
	task automatic accept_req(input enc_req_t it, input bit typed, input logic [5:0] typed_sym);
		enc_rsp_t due;
		case (it.req_type)
			REQ_MATRIX: begin
				gen_mem[it.row_index][it.col_index]    = it.symbol_value;
				gen_loaded[it.row_index][it.col_index] = 1'b1;
			end
			REQ_INFO: begin
				msg_mem[it.col_index]    = it.symbol_value;
				msg_loaded[it.col_index] = 1'b1;
			end
			REQ_PARITY: begin
				due.parity_index  = it.row_index;
				due.parity_symbol = typed ? typed_sym : predict_parity(it.row_index);
				parity_due.push_back(due);
			end
			default: begin
			end
		endcase
	endtask

	// Entered and left at a falling edge. The gap before the next item is
	// drawn as soon as this one is taken: valid is lowered only when the gap is
	// non-zero, so a back-to-back item never sees valid drop and rise in one step.
	task automatic send_req(input enc_req_t it, input bit typed, input logic [5:0] typed_sym);
		if (pend_gap > 0) begin
			repeat (pend_gap) @(negedge clk);
		end
		req       <= it;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) begin
			@(posedge clk);
		end
		accept_req(it, typed, typed_sym);
		n_items++;
		@(negedge clk);
		pend_gap = draw_gap();
		if (pend_gap > 0) begin
			req_valid <= 1'b0;
		end
	endtask

	// Writes every message position and matrix entry that a parity item for
	// this row will read and that has not yet been given a value.
	task automatic load_row_deps(input logic [6:0] r);
		for (int j = 0; j < eff_len(); j++) begin
			if (!msg_loaded[j]) begin
				send_req(make_req(REQ_INFO, 7'($urandom_range(0, 127)), 7'(j), rand_sym()), 1'b0, '0);
			end
			if (!gen_loaded[r][j]) begin
				send_req(make_req(REQ_MATRIX, r, 7'(j), rand_sym()), 1'b0, '0);
			end
		end
	endtask

	// Drops valid, waits until every owed result has arrived and then lets the
	// block finish any write still in flight.
	task automatic quiesce();
		if (pend_gap == 0) begin
			req_valid <= 1'b0;
		end
		while (parity_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (HOLD_CYCLES) @(negedge clk);
		pend_gap = 0;
	endtask

	task automatic set_length(input logic [7:0] v);
		quiesce();
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		len_reg = v;
		n_cfg++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// A random phase: mostly well-formed load-then-compute sequences, with
	// stray writes and unused codes mixed in. The writes that load a row
	// before its parity item are not counted.
	task automatic run_phase(input int count);
		int         done;
		int         pick;
		logic [6:0] r;
		done = 0;
		while (done < count) begin
			if (done % 30 == 0) begin
				no_idle = ($urandom_range(0, 3) == 0);
			end
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				send_req(make_req(REQ_MATRIX, pick_row(), pick_col(eff_len()), rand_sym()), 1'b0, '0);
			end else if (pick < 50) begin
				send_req(make_req(REQ_INFO, 7'($urandom_range(0, 127)), pick_col(eff_len()),
					rand_sym()), 1'b0, '0);
			end else if (pick < 95) begin
				r = pick_parity_row();
				load_row_deps(r);
				send_req(make_req(REQ_PARITY, r, 7'($urandom_range(0, 127)), rand_sym()), 1'b0, '0);
			end else begin
				send_req(make_req(REQ_UNUSED, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
					6'($urandom_range(0, 63))), 1'b0, '0);
			end
			done++;
		end
	endtask

	// The receiver holds off each result for a freshly drawn number of cycles
	// once it shows up, so stalls land on results that have just appeared and
	// on results that the block has had to keep back.
	always @(negedge clk) begin
		if (rsp_valid === 1'b1 && rsp_wait > 0) begin
			rsp_stall <= 1'b1;
			rsp_wait  = rsp_wait - 1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// Every result taken is matched against the oldest owed one.
	always @(posedge clk) begin
		enc_rsp_t due;
		if (arst_n && rsp_valid && !rsp_stall) begin
			rsp_wait = draw_gap();
			if (parity_due.size() == 0) begin
				report_mismatch("result with nothing pending, parity_index", 32'(rsp.parity_index), '0);
			end else begin
				due = parity_due.pop_front();
				n_results++;
				if (rsp.parity_index !== due.parity_index) begin
					report_mismatch("parity_index", 32'(rsp.parity_index), 32'(due.parity_index));
				end
				if (rsp.parity_symbol !== due.parity_symbol) begin
					report_mismatch("parity_symbol", 32'(rsp.parity_symbol), 32'(due.parity_symbol));
				end
			end
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles with %0d results outstanding.", n_cycles,
				parity_due.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		enc_req_t   it;
		logic [7:0] phase_len;

		// Directed part, run at the reset length of 100. The message is set to
		// the field's unit, so a row of identical entries sums to zero over an
		// even count and to the entry itself over an odd count.
		dir_tab = '{
			step_row(1'b1, 1'b0, 6'h00, REQ_INFO,   7'd0,   7'd0,   6'h01),
			step_row(1'b1, 1'b0, 6'h00, REQ_MATRIX, 7'd0,   7'd0,   6'h3F),
			step_row(1'b0, 1'b1, 6'h00, REQ_PARITY, 7'd0,   7'd0,   6'h00),
			// Clearing the last column inside the length leaves 99 terms.
			step_row(1'b0, 1'b0, 6'h00, REQ_MATRIX, 7'd0,   7'd99,  6'h00),
			step_row(1'b0, 1'b1, 6'h3F, REQ_PARITY, 7'd0,   7'd127, 6'h3F),
			// A column just past the length must not contribute.
			step_row(1'b0, 1'b0, 6'h00, REQ_MATRIX, 7'd0,   7'd100, 6'h15),
			step_row(1'b0, 1'b1, 6'h3F, REQ_PARITY, 7'd0,   7'd0,   6'h00),
			// A row of zero factors gives zero whatever the message holds.
			step_row(1'b1, 1'b0, 6'h00, REQ_MATRIX, 7'd127, 7'd0,   6'h00),
			step_row(1'b0, 1'b1, 6'h00, REQ_PARITY, 7'd127, 7'd0,   6'h3F),
			step_row(1'b0, 1'b0, 6'h00, REQ_INFO,   7'd127, 7'd0,   6'h3F),
			step_row(1'b0, 1'b0, 6'h00, REQ_MATRIX, 7'd127, 7'd0,   6'h3F),
			step_row(1'b0, 1'b0, 6'h00, REQ_PARITY, 7'd127, 7'd64,  6'h2A),
			step_row(1'b0, 1'b0, 6'h00, REQ_INFO,   7'd0,   7'd127, 6'h2A),
			step_row(1'b0, 1'b0, 6'h00, REQ_MATRIX, 7'd127, 7'd127, 6'h3F),
			step_row(1'b0, 1'b0, 6'h00, REQ_UNUSED, 7'd127, 7'd127, 6'h3F),
			step_row(1'b0, 1'b0, 6'h00, REQ_PARITY, 7'd127, 7'd127, 6'h00),
			step_row(1'b0, 1'b0, 6'h00, REQ_MATRIX, 7'd0,   7'd1,   6'h20),
			step_row(1'b0, 1'b0, 6'h00, REQ_INFO,   7'd85,  7'd1,   6'h21),
			// Two parity items in a row for the same row.
			step_row(1'b0, 1'b0, 6'h00, REQ_PARITY, 7'd0,   7'd42,  6'h15),
			step_row(1'b0, 1'b0, 6'h00, REQ_PARITY, 7'd0,   7'd85,  6'h2A),
			step_row(1'b0, 1'b0, 6'h00, REQ_MATRIX, 7'd127, 7'd50,  6'h01),
			step_row(1'b0, 1'b0, 6'h00, REQ_PARITY, 7'd127, 7'd0,   6'h00)
		};

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_CNT; i++) begin
			if (dir_tab[i].fill) begin
				for (int c = 0; c < SYM_CNT; c++) begin
					it           = dir_tab[i].item;
					it.col_index = 7'(c);
					send_req(it, 1'b0, '0);
				end
			end else begin
				send_req(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].sym);
			end
		end

		// Random part: first at the reset length, then at the extremes (one, full
		// size, zero, the register's top value), at five and just past full size,
		// then at a few short random lengths that keep the walks quick.
		run_phase(PHASE_ITEMS);
		for (int p = 0; p < 10; p++) begin
			case (p)
				0:       phase_len = 8'd1;
				1:       phase_len = 8'd128;
				2:       phase_len = 8'd0;
				3:       phase_len = 8'd255;
				4:       phase_len = 8'd5;
				5:       phase_len = 8'd129;
				default: phase_len = 8'($urandom_range(0, 16));
			endcase
			set_length(phase_len);
			run_phase(PHASE_ITEMS);
		end

		quiesce();

		$display("Run covered %0d items and %0d checked parity results over %0d length settings,",
			n_items, n_results, n_cfg + 1);
		$display("from an empty sum to lengths saturating above the memory size.");
		if (err_cnt == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches seen.", err_cnt);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
